FILE: design/ccpd_pkg.sv
// ----------------------------------------------------------------------------
// ccpd_pkg
// Shared types, constants and the bytewise CRC-16-CCITT function for the
// COBS/CRC packet decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ccpd_pkg;

    // Frame limits.
    localparam int unsigned MAX_PAYLOAD = 256;
    localparam int unsigned RAW_LIMIT   = MAX_PAYLOAD + 8;

    // CRC-16-CCITT.
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // COBS code that opens a full block with no implied zero.
    localparam logic [7:0] COBS_FULL_CODE = 8'hFF;

    // Header layout in raw byte positions.
    localparam logic [15:0] IDX_VERSION = 16'd0;
    localparam logic [15:0] IDX_TYPE    = 16'd1;
    localparam logic [15:0] IDX_SEQ_LO  = 16'd2;
    localparam logic [15:0] IDX_SEQ_HI  = 16'd3;
    localparam logic [15:0] IDX_LEN_LO  = 16'd4;
    localparam logic [15:0] IDX_LEN_HI  = 16'd5;
    localparam logic [15:0] HDR_BYTES   = 16'd6;
    localparam logic [15:0] FRAME_OVH   = 16'd8;

    // Summary status codes.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_COBS    = 3'd1;
    localparam logic [2:0] ST_LENGTH  = 3'd2;
    localparam logic [2:0] ST_CRC     = 3'd3;
    localparam logic [2:0] ST_VERSION = 3'd4;

    // Result queue sizing.
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0] enc_byte;
        logic       frame_last;
    } in_item_t;

    typedef struct packed {
        logic        is_summary;
        logic [7:0]  payload_byte;
        logic [2:0]  status;
        logic [7:0]  msg_kind;
        logic [15:0] sequence_res;
        logic [15:0] payload_len;
    } out_item_t;

    // Everything one input transaction produces: an optional payload byte
    // followed by an optional end-of-frame summary.
    typedef struct packed {
        logic      pay_valid;
        logic      sum_valid;
        out_item_t pay;
        out_item_t sum;
    } res_pair_t;

    // One byte through CRC-16-CCITT, MSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  v);
        logic [15:0] c;
        c = crc_in ^ {v, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: design/ccpd_core.sv
// ----------------------------------------------------------------------------
// ccpd_core
// Per-frame COBS decode, header capture, CRC hold line and status check.
// Consumes one registered input byte per firing cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ccpd_core (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                fire,
    input  wire ccpd_pkg::in_item_t  in_item,
    input  wire logic [7:0]          expected_version,
    output ccpd_pkg::res_pair_t      pair
);

    logic [7:0]  block_left_reg,   block_left_next;
    logic        await_code_reg,   await_code_next;
    logic        zero_pending_reg, zero_pending_next;
    logic [15:0] raw_count_reg,    raw_count_next;
    logic [15:0] crc_reg,          crc_next;
    logic [7:0]  hold0_reg,        hold0_next;
    logic [7:0]  hold1_reg,        hold1_next;
    logic [7:0]  version_reg,      version_next;
    logic [7:0]  type_reg,         type_next;
    logic [15:0] seq_reg,          seq_next;
    logic [15:0] len_reg,          len_next;
    logic        failed_reg,       failed_next;

    logic        overflow;
    logic        push_en;
    logic [7:0]  push_val;
    logic        len_ok;
    logic [2:0]  status;

    // A raw byte at this index would exceed the frame capacity.
    assign overflow = ({1'b0, raw_count_reg} >= 17'(ccpd_pkg::RAW_LIMIT)) ||
                      (raw_count_reg == 16'hFFFF);

    always_comb begin
        block_left_next   = block_left_reg;
        await_code_next   = await_code_reg;
        zero_pending_next = zero_pending_reg;
        raw_count_next    = raw_count_reg;
        crc_next          = crc_reg;
        hold0_next        = hold0_reg;
        hold1_next        = hold1_reg;
        version_next      = version_reg;
        type_next         = type_reg;
        seq_next          = seq_reg;
        len_next          = len_reg;
        failed_next       = failed_reg;
        push_en           = 1'b0;
        push_val          = 8'h00;
        pair              = '0;
        len_ok            = 1'b0;
        status            = ccpd_pkg::ST_OK;

        // COBS decode: at most one raw byte comes out per encoded byte.
        if (!failed_reg) begin
            if (await_code_reg) begin
                if (zero_pending_reg) begin
                    zero_pending_next = 1'b0;
                    push_en           = 1'b1;
                end
                if (!(push_en && overflow)) begin
                    if (in_item.enc_byte == 8'h00) begin
                        failed_next = 1'b1;
                    end else begin
                        block_left_next   = in_item.enc_byte - 8'd1;
                        zero_pending_next = (in_item.enc_byte != ccpd_pkg::COBS_FULL_CODE);
                        await_code_next   = (in_item.enc_byte == 8'd1);
                    end
                end
            end else begin
                push_en  = 1'b1;
                push_val = in_item.enc_byte;
                if (block_left_reg != 8'd0) begin
                    block_left_next = block_left_reg - 8'd1;
                end
                if (block_left_reg <= 8'd1) begin
                    await_code_next = 1'b1;
                end
            end
        end

        // Raw byte handling: header capture, payload emission, CRC hold line.
        if (push_en) begin
            if (overflow) begin
                failed_next = 1'b1;
            end else begin
                if (raw_count_reg == ccpd_pkg::IDX_VERSION) begin
                    version_next = push_val;
                end
                if (raw_count_reg == ccpd_pkg::IDX_TYPE) begin
                    type_next = push_val;
                end
                if (raw_count_reg == ccpd_pkg::IDX_SEQ_LO) begin
                    seq_next[7:0] = push_val;
                end
                if (raw_count_reg == ccpd_pkg::IDX_SEQ_HI) begin
                    seq_next[15:8] = push_val;
                end
                if (raw_count_reg == ccpd_pkg::IDX_LEN_LO) begin
                    len_next[7:0] = push_val;
                end
                if (raw_count_reg == ccpd_pkg::IDX_LEN_HI) begin
                    len_next[15:8] = push_val;
                end
                if ((raw_count_reg >= ccpd_pkg::HDR_BYTES) &&
                    ({1'b0, len_reg} <= 17'(ccpd_pkg::MAX_PAYLOAD)) &&
                    ((raw_count_reg - ccpd_pkg::HDR_BYTES) < len_reg)) begin
                    pair.pay_valid        = 1'b1;
                    pair.pay.payload_byte = push_val;
                end
                if (raw_count_reg >= ccpd_pkg::IDX_SEQ_LO) begin
                    crc_next = ccpd_pkg::crc_byte(crc_reg, hold0_reg);
                end
                hold0_next     = hold1_reg;
                hold1_next     = push_val;
                raw_count_next = raw_count_reg + 16'd1;
            end
        end

        // End-of-frame summary, checked in priority order.
        if (in_item.frame_last) begin
            len_ok = (raw_count_next >= ccpd_pkg::FRAME_OVH) &&
                     ({1'b0, len_next} <= 17'(ccpd_pkg::MAX_PAYLOAD)) &&
                     ({1'b0, raw_count_next} ==
                      ({1'b0, len_next} + {1'b0, ccpd_pkg::FRAME_OVH}));
            priority if (failed_next || !await_code_next || raw_count_next == 16'd0) begin
                status = ccpd_pkg::ST_COBS;
            end else if (!len_ok) begin
                status = ccpd_pkg::ST_LENGTH;
            end else if ({hold1_next, hold0_next} != crc_next) begin
                status = ccpd_pkg::ST_CRC;
            end else if (version_next != expected_version) begin
                status = ccpd_pkg::ST_VERSION;
            end else begin
                status = ccpd_pkg::ST_OK;
            end
            pair.sum_valid        = 1'b1;
            pair.sum.is_summary   = 1'b1;
            pair.sum.status       = status;
            pair.sum.msg_kind     = type_next;
            pair.sum.sequence_res = seq_next;
            pair.sum.payload_len  = len_next;

            // Frame done: every piece of frame state starts over.
            block_left_next   = 8'd0;
            await_code_next   = 1'b1;
            zero_pending_next = 1'b0;
            raw_count_next    = 16'd0;
            crc_next          = ccpd_pkg::CRC_INIT;
            hold0_next        = 8'd0;
            hold1_next        = 8'd0;
            version_next      = 8'd0;
            type_next         = 8'd0;
            seq_next          = 16'd0;
            len_next          = 16'd0;
            failed_next       = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_left_reg   <= 8'd0;
            await_code_reg   <= 1'b1;
            zero_pending_reg <= 1'b0;
            raw_count_reg    <= 16'd0;
            crc_reg          <= ccpd_pkg::CRC_INIT;
            hold0_reg        <= 8'd0;
            hold1_reg        <= 8'd0;
            version_reg      <= 8'd0;
            type_reg         <= 8'd0;
            seq_reg          <= 16'd0;
            len_reg          <= 16'd0;
            failed_reg       <= 1'b0;
        end else if (fire) begin
            block_left_reg   <= block_left_next;
            await_code_reg   <= await_code_next;
            zero_pending_reg <= zero_pending_next;
            raw_count_reg    <= raw_count_next;
            crc_reg          <= crc_next;
            hold0_reg        <= hold0_next;
            hold1_reg        <= hold1_next;
            version_reg      <= version_next;
            type_reg         <= type_next;
            seq_reg          <= seq_next;
            len_reg          <= len_next;
            failed_reg       <= failed_next;
        end
    end

    // While data bytes of a block are due, at least one is still owed.
    a_block_owed: assert property (@(posedge aclk) disable iff (!aresetn)
        !await_code_reg |-> block_left_reg != 8'd0)
        else $error("ccpd_core: data state with no data bytes owed");

    // The raw byte count never runs past the frame capacity.
    a_raw_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, raw_count_reg} <= 17'(ccpd_pkg::RAW_LIMIT))
        else $error("ccpd_core: raw count beyond capacity");

    // After a frame-end byte is consumed, the frame state is back to idle.
    a_frame_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_item.frame_last |=> raw_count_reg == 16'd0 && await_code_reg &&
                                       !failed_reg && crc_reg == ccpd_pkg::CRC_INIT)
        else $error("ccpd_core: frame state not cleared after frame end");

endmodule

`default_nettype wire

FILE: design/ccpd_res_queue.sv
// ----------------------------------------------------------------------------
// ccpd_res_queue
// Small result queue. Each entry holds what one input transaction produced
// (payload byte and/or summary); the two halves are sent in that order.
// ----------------------------------------------------------------------------
`default_nettype none

module ccpd_res_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire ccpd_pkg::res_pair_t  push_data,
    output logic                      full,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output ccpd_pkg::out_item_t       m_item
);

    ccpd_pkg::res_pair_t              mem_reg [ccpd_pkg::QDEPTH];
    logic [ccpd_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [ccpd_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [ccpd_pkg::QCNT_W-1:0]      count_reg,  count_next;
    logic                             pay_done_reg, pay_done_next;

    ccpd_pkg::res_pair_t              head;
    logic                             show_pay;
    logic                             pop;
    logic                             retire;

    assign head     = mem_reg[rd_ptr_reg];
    assign m_valid  = (count_reg != '0);
    assign full     = (count_reg == ccpd_pkg::QCNT_W'(ccpd_pkg::QDEPTH));
    assign show_pay = head.pay_valid && !pay_done_reg;
    assign m_item   = show_pay ? head.pay : head.sum;
    assign pop      = m_valid && m_ready;
    assign retire   = pop && !(show_pay && head.sum_valid);

    always_comb begin
        wr_ptr_next   = push ? wr_ptr_reg + ccpd_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next   = retire ? rd_ptr_reg + ccpd_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next    = count_reg;
        pay_done_next = pay_done_reg;
        if (push && !retire) begin
            count_next = count_reg + ccpd_pkg::QCNT_W'(1);
        end else if (!push && retire) begin
            count_next = count_reg - ccpd_pkg::QCNT_W'(1);
        end
        if (retire) begin
            pay_done_next = 1'b0;
        end else if (pop) begin
            pay_done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
            pay_done_reg <= 1'b0;
        end else begin
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            count_reg    <= count_next;
            pay_done_reg <= pay_done_next;
        end
    end

    // Nothing is ever written into a full queue.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("ccpd_res_queue: push into a full queue");

    // A stored entry always carries at least one result.
    a_head_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (head.pay_valid || head.sum_valid))
        else $error("ccpd_res_queue: empty entry at head");

    // The payload half is marked sent only for an entry that still has a summary.
    a_half_sent: assert property (@(posedge aclk) disable iff (!aresetn)
        pay_done_reg |-> (m_valid && head.pay_valid && head.sum_valid))
        else $error("ccpd_res_queue: half-sent mark on wrong entry");

endmodule

`default_nettype wire

FILE: design/cobs_crc_packet_decoder_unit.sv
// ----------------------------------------------------------------------------
// cobs_crc_packet_decoder_unit
// COBS deframer with CRC-16-CCITT check, header capture and cut-through
// payload output.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                         Carries
//  --------  ----------------------------  ------------------------------------
//  input     s_valid, s_ready, s_item      one encoded byte plus frame-end flag
//  result    m_valid, m_ready, m_item      payload byte or end-of-frame summary
//  config    cfg_wr_en, cfg_wr_data        expected protocol version byte
//
//  An accepted transaction lands in an input register and is decoded from
//  there whenever the result queue has a free entry, so the block takes
//  one byte per cycle; its results are written into the queue first.
//  A frame-end byte can produce two results (last payload byte and summary),
//  which leave the result port one after the other; the four-entry queue absorbs this.
//  A stall on m_ready fills the queue, then holds the input register, and
//  s_ready drops. Reset (aresetn, synchronous, active low) empties both stages,
//  clears frame state and sets the expected version to 1.
//
`default_nettype none

module cobs_crc_packet_decoder_unit (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire ccpd_pkg::in_item_t   s_item,

    output logic                      m_valid,
    input  wire logic                 m_ready,
    output ccpd_pkg::out_item_t       m_item,

    input  wire logic                 cfg_wr_en,
    input  wire logic [7:0]           cfg_wr_data
);

    // Input register: one encoded byte waiting to be decoded.
    logic                 in_valid_reg, in_valid_next;
    ccpd_pkg::in_item_t   in_item_reg;
    logic [7:0]           exp_version_reg;

    logic                 q_full;
    logic                 fire;
    ccpd_pkg::res_pair_t  pair;
    logic                 push;

    // The held byte is decoded whenever the queue can take its results, and
    // the input register refills in the same cycle.
    assign fire    = in_valid_reg && !q_full;
    assign s_ready = !in_valid_reg || fire;
    assign push    = fire && (pair.pay_valid || pair.sum_valid);

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            exp_version_reg <= 8'd1;
        end else begin
            in_valid_reg <= in_valid_next;
            if (cfg_wr_en) begin
                exp_version_reg <= cfg_wr_data;
            end
        end
    end

    // Payload register: only loaded on a completed input transaction.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    ccpd_core u_core (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .fire             (fire),
        .in_item          (in_item_reg),
        .expected_version (exp_version_reg),
        .pair             (pair)
    );

    ccpd_res_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (pair),
        .full      (q_full),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    // A byte held back by a full queue is decoded as soon as the queue drains.
    a_hold_until_room: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && q_full |=> in_valid_reg)
        else $error("cobs_crc_packet_decoder_unit: held byte lost");

    // A frame-end byte always yields a summary when it is decoded.
    a_summary_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_item_reg.frame_last |-> pair.sum_valid)
        else $error("cobs_crc_packet_decoder_unit: frame end without summary");

endmodule

`default_nettype wire
